// ===== src/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

   localparam logic [7:0]  SYNC_BYTE = 8'h55;
   localparam logic [15:0] CRC_INIT  = 16'h1D0F;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   // frames whose offset runs past this are cut off
   localparam logic [10:0] MAX_FRAME = 11'd256;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_PLAIN,
      KIND_CRC_DATA,
      KIND_CRC_HIGH,
      KIND_CRC_CHECK,
      KIND_ABORT
   } item_kind_type;

   typedef enum logic [1:0] {
      STATUS_IN_FRAME,
      STATUS_CRC_GOOD,
      STATUS_CRC_ERROR,
      STATUS_ABORTED
   } frame_status_type;

   typedef struct packed {
      logic [7:0]    frame_byte;
      logic [8:0]    byte_offset;
      logic [7:0]    payload_length;
      item_kind_type kind;
   } queue_entry_type;

   // one byte through crc-16/ccitt, msb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/sfd_front.sv =====
`timescale 1ns / 1ps

module sfd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_rx_byte,
   output logic                     push_valid,
   input  logic                     push_ready,
   output sfd_pkg::queue_entry_type push_entry
);

   logic       in_frame_ff, in_frame_in;
   logic       prev_sync_ff, prev_sync_in;
   logic [8:0] offset_ff, offset_in;
   logic [7:0] length_ff, length_in;

   logic       accept;
   logic       is_sync;
   logic [8:0] next_offset;
   logic [8:0] crc_high_offset;
   logic [8:0] crc_low_offset;
   logic       is_data;
   logic       is_high;
   logic       is_check;
   logic       is_abort;
   logic [7:0] length_out;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign is_sync   = (req_rx_byte == sfd_pkg::SYNC_BYTE);

   assign next_offset     = offset_ff + 9'd1;
   assign crc_high_offset = {1'b0, length_ff} + 9'd5;
   assign crc_low_offset  = {1'b0, length_ff} + 9'd6;

   assign is_data  = (next_offset <= 9'd4) || (next_offset < crc_high_offset);
   assign is_high  = !is_data && (next_offset == crc_high_offset);
   assign is_check = !is_data && (next_offset == crc_low_offset);
   assign is_abort = !is_check && ({2'b00, next_offset} > sfd_pkg::MAX_FRAME);

   always_comb begin
      if (next_offset == 9'd4) begin
         length_out = req_rx_byte;
      end else if (next_offset > 9'd4) begin
         length_out = length_ff;
      end else begin
         length_out = 8'd0;
      end
   end

   always_comb begin
      push_entry.frame_byte     = req_rx_byte;
      push_entry.byte_offset    = next_offset;
      push_entry.payload_length = length_out;
      if (is_check) begin
         push_entry.kind = sfd_pkg::KIND_CRC_CHECK;
      end else if (is_abort) begin
         push_entry.kind = sfd_pkg::KIND_ABORT;
      end else if (is_high) begin
         push_entry.kind = sfd_pkg::KIND_CRC_HIGH;
      end else if (is_data) begin
         push_entry.kind = sfd_pkg::KIND_CRC_DATA;
      end else begin
         push_entry.kind = sfd_pkg::KIND_PLAIN;
      end
   end

   assign push_valid = accept && in_frame_ff;

   always_comb begin
      in_frame_in  = in_frame_ff;
      prev_sync_in = prev_sync_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (is_sync && prev_sync_ff) begin
               in_frame_in  = 1'b1;
               prev_sync_in = 1'b0;
               offset_in    = 9'd1;
               length_in    = 8'd0;
            end else begin
               prev_sync_in = is_sync;
            end
         end else begin
            offset_in = next_offset;
            if (next_offset == 9'd4) begin
               length_in = req_rx_byte;
            end
            if (is_check || is_abort) begin
               in_frame_in  = 1'b0;
               prev_sync_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         prev_sync_ff <= 1'b0;
         offset_ff    <= 9'd0;
         length_ff    <= 8'd0;
      end else begin
         in_frame_ff  <= in_frame_in;
         prev_sync_ff <= prev_sync_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
      end
   end

   // sync pair tracking only runs while hunting
   assert property (@(posedge clock) disable iff (reset)
      !(in_frame_ff && prev_sync_ff))
      else $error("sync flag set while inside a frame");

   // a frame never runs past its crc bytes without ending
   assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (offset_ff < crc_low_offset))
      else $error("frame offset past crc without end");

endmodule

// ===== src/sfd_queue.sv =====
`timescale 1ns / 1ps

module sfd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  sfd_pkg::queue_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output sfd_pkg::queue_entry_type pop_entry
);

   localparam int PtrW   = sfd_pkg::QUEUE_PTR_W;
   localparam int CountW = sfd_pkg::QUEUE_COUNT_W;

   sfd_pkg::queue_entry_type entries_ff [sfd_pkg::QUEUE_DEPTH];

   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff < CountW'(sfd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(sfd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // the front only pushes on a transfer it was allowed to take
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("push into full queue");

endmodule

// ===== src/sfd_back.sv =====
`timescale 1ns / 1ps

module sfd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  sfd_pkg::queue_entry_type pop_entry,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_frame_byte,
   output logic [8:0]               rsp_byte_offset,
   output logic [7:0]               rsp_payload_length,
   output logic                     rsp_frame_end,
   output logic [1:0]               rsp_frame_status
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_frame_byte_ff;
   logic [8:0]  rsp_byte_offset_ff;
   logic [7:0]  rsp_payload_length_ff;
   logic        rsp_frame_end_ff, rsp_frame_end_in;
   sfd_pkg::frame_status_type rsp_frame_status_ff, rsp_frame_status_in;

   logic do_pop;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      crc_in              = crc_ff;
      crc_high_in         = crc_high_ff;
      rsp_frame_end_in    = 1'b0;
      rsp_frame_status_in = sfd_pkg::STATUS_IN_FRAME;
      case (pop_entry.kind)
         sfd_pkg::KIND_CRC_DATA: begin
            crc_in = sfd_pkg::crc16_update(crc_ff, pop_entry.frame_byte);
         end
         sfd_pkg::KIND_CRC_HIGH: begin
            crc_high_in = pop_entry.frame_byte;
         end
         sfd_pkg::KIND_CRC_CHECK: begin
            rsp_frame_end_in    = 1'b1;
            rsp_frame_status_in = ({crc_high_ff, pop_entry.frame_byte} == crc_ff) ?
                                  sfd_pkg::STATUS_CRC_GOOD : sfd_pkg::STATUS_CRC_ERROR;
            crc_in              = sfd_pkg::CRC_INIT;
         end
         sfd_pkg::KIND_ABORT: begin
            rsp_frame_end_in    = 1'b1;
            rsp_frame_status_in = sfd_pkg::STATUS_ABORTED;
            crc_in              = sfd_pkg::CRC_INIT;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         crc_ff       <= sfd_pkg::CRC_INIT;
         crc_high_ff  <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_pop) begin
            crc_ff      <= crc_in;
            crc_high_ff <= crc_high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rsp_frame_byte_ff     <= pop_entry.frame_byte;
         rsp_byte_offset_ff    <= pop_entry.byte_offset;
         rsp_payload_length_ff <= pop_entry.payload_length;
         rsp_frame_end_ff      <= rsp_frame_end_in;
         rsp_frame_status_ff   <= rsp_frame_status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_byte     = rsp_frame_byte_ff;
   assign rsp_byte_offset    = rsp_byte_offset_ff;
   assign rsp_payload_length = rsp_payload_length_ff;
   assign rsp_frame_end      = rsp_frame_end_ff;
   assign rsp_frame_status   = rsp_frame_status_ff;

   // end flag and status always agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_frame_end_ff == (rsp_frame_status_ff != sfd_pkg::STATUS_IN_FRAME)))
      else $error("frame end and status disagree");

   // each new frame starts from the crc seed
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && rsp_frame_end_in) |=> (crc_ff == sfd_pkg::CRC_INIT))
      else $error("crc not reseeded after frame end");

endmodule

// ===== src/sync_frame_deframer_crc16_unit.sv =====
`timescale 1ns / 1ps

// Deframer for a sync-word serial stream with a crc-16/ccitt check.
// Input channel req_*: one received byte per transfer (req_rx_byte).
// Hunts for two 0x55 bytes in a row; those produce no result. From then on
// every frame byte comes out on rsp_* with its offset (2 upward), the declared
// payload length (from offset 4 on) and, on the last byte, rsp_frame_end with
// the status: crc good, crc error, or aborted when the offset passes the
// frame limit. The crc covers type, length and payload, seed 0x1D0F.
// A byte passes the classifier, a two-entry queue and the byte-wide crc stage
// with its output register, in that order. Throughput: one byte per cycle
// while rsp_ready stays high.
// Reset (synchronous, active high) returns to hunting, empties the queue and
// drops rsp_valid. When rsp_ready is low the result holds in its output
// register, the queue fills, and req_ready falls once both entries are used.
module sync_frame_deframer_crc16_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic [8:0] rsp_byte_offset,
   output logic [7:0] rsp_payload_length,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_frame_status
);

   logic                     push_valid;
   logic                     push_ready;
   sfd_pkg::queue_entry_type push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   sfd_pkg::queue_entry_type pop_entry;

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   sfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   sfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_entry          (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_status   (rsp_frame_status)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic [8:0] rsp_byte_offset;
   logic [7:0] rsp_payload_length;
   logic       rsp_frame_end;
   logic [1:0] rsp_frame_status;

   sync_frame_deframer_crc16_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_status   (rsp_frame_status)
   );

   always #5 clock = ~clock;

   typedef struct packed {
      logic [7:0]                frame_byte;
      logic [8:0]                byte_offset;
      logic [7:0]                payload_length;
      logic                      frame_end;
      sfd_pkg::frame_status_type frame_status;
   } frame_out_type;

   // where a directed byte comes from: the table, or the running crc
   typedef enum logic [1:0] {
      FEED_RAW,
      FEED_CRC_HIGH,
      FEED_CRC_LOW,
      FEED_CRC_LOW_BAD
   } feed_kind_type;

   typedef struct packed {
      logic [7:0]                value;
      feed_kind_type             feed;
      logic                      typed;
      logic                      none;
      logic [8:0]                offset;
      logic [7:0]                plen;
      logic                      fend;
      sfd_pkg::frame_status_type status;
   } dir_row_type;

   localparam int DIR_ROWS = 29;

   dir_row_type directed_rows [DIR_ROWS] = '{
      // stray bytes while hunting, a lone sync, then a real sync pair
      '{8'h00, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'hFF, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      // empty payload, good crc
      '{8'h00, FEED_RAW, 1'b1, 1'b0, 9'd2, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'hFF, FEED_RAW, 1'b1, 1'b0, 9'd3, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_RAW, 1'b1, 1'b0, 9'd4, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_CRC_HIGH, 1'b1, 1'b0, 9'd5, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_CRC_LOW, 1'b1, 1'b0, 9'd6, 8'd0, 1'b1, sfd_pkg::STATUS_CRC_GOOD},
      // three 0x55 in a row: the third is the first type byte
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b0, 9'd2, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'hFF, FEED_RAW, 1'b1, 1'b0, 9'd3, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h01, FEED_RAW, 1'b1, 1'b0, 9'd4, 8'd1, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h80, FEED_RAW, 1'b0, 1'b0, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_CRC_HIGH, 1'b1, 1'b0, 9'd6, 8'd1, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_CRC_LOW_BAD, 1'b1, 1'b0, 9'd7, 8'd1, 1'b1, sfd_pkg::STATUS_CRC_ERROR},
      // sync pair broken by another byte, then resynced
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h55, FEED_RAW, 1'b1, 1'b1, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'hAA, FEED_RAW, 1'b1, 1'b0, 9'd2, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h5A, FEED_RAW, 1'b1, 1'b0, 9'd3, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h02, FEED_RAW, 1'b1, 1'b0, 9'd4, 8'd2, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_RAW, 1'b0, 1'b0, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'hFF, FEED_RAW, 1'b0, 1'b0, 9'd0, 8'd0, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_CRC_HIGH, 1'b1, 1'b0, 9'd7, 8'd2, 1'b0, sfd_pkg::STATUS_IN_FRAME},
      '{8'h00, FEED_CRC_LOW, 1'b1, 1'b0, 9'd8, 8'd2, 1'b1, sfd_pkg::STATUS_CRC_GOOD}
   };

   // deframer shadow state
   bit          synced = 1'b0;
   bit          saw_sync = 1'b0;
   logic [8:0]  pos = 9'd0;
   logic [7:0]  declared_len = 8'd0;
   logic [15:0] crc_acc = sfd_pkg::CRC_INIT;
   logic [7:0]  crc_hi_byte = 8'd0;

   frame_out_type frame_byte_queue [$];
   int            fail_count = 0;
   int            fed_items = 0;
   int            stall_left = 0;
   bit            tx_idle_on = 1'b1;
   bit            rx_stall_on = 1'b1;

   // bit-serial form of the msb-first ccitt update
   function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0};
         if (fb) c = c ^ 16'h1021;
      end
      return c;
   endfunction

   task automatic deframe_step(input logic [7:0] b, output bit has_out,
                               output frame_out_type o);
      int p;
      int l;
      has_out = 1'b0;
      o = '0;
      if (!synced) begin
         if (b == sfd_pkg::SYNC_BYTE && saw_sync) begin
            synced       = 1'b1;
            saw_sync     = 1'b0;
            pos          = 9'd1;
            declared_len = 8'd0;
            crc_acc      = sfd_pkg::CRC_INIT;
            crc_hi_byte  = 8'd0;
         end else begin
            saw_sync = (b == sfd_pkg::SYNC_BYTE);
         end
         return;
      end
      pos = pos + 9'd1;
      p = int'(pos);
      o.frame_status = sfd_pkg::STATUS_IN_FRAME;
      if (p <= 4) begin
         if (p == 4) declared_len = b;
         crc_acc = ccitt_next(crc_acc, b);
      end else begin
         l = int'(declared_len);
         if (p < 5 + l) begin
            crc_acc = ccitt_next(crc_acc, b);
         end else if (p == 5 + l) begin
            crc_hi_byte = b;
         end else if (p == 6 + l) begin
            o.frame_end    = 1'b1;
            o.frame_status = ({crc_hi_byte, b} == crc_acc) ?
                             sfd_pkg::STATUS_CRC_GOOD : sfd_pkg::STATUS_CRC_ERROR;
         end
      end
      // a proper end wins over the length limit
      if (!o.frame_end && p > int'(sfd_pkg::MAX_FRAME)) begin
         o.frame_end    = 1'b1;
         o.frame_status = sfd_pkg::STATUS_ABORTED;
      end
      o.frame_byte     = b;
      o.byte_offset    = pos;
      o.payload_length = (p >= 4) ? declared_len : 8'd0;
      if (o.frame_end) begin
         synced   = 1'b0;
         saw_sync = 1'b0;
      end
      has_out = 1'b1;
   endtask

   task automatic push_byte(input logic [7:0] b);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic feed_byte(input logic [7:0] b);
      bit            has;
      frame_out_type o;
      push_byte(b);
      deframe_step(b, has, o);
      fed_items++;
      if (has) begin
         frame_byte_queue.insert(frame_byte_queue.size(), o);
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return sfd_pkg::SYNC_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // flaw 0 clean, 1 corrupted crc, 2 cut short
   task automatic send_frame(input int plen, input int flaw);
      logic [7:0]  body [$];
      logic [15:0] crc;
      int          keep;
      body.delete();
      crc = sfd_pkg::CRC_INIT;
      body.insert(body.size(), pick_byte());
      body.insert(body.size(), pick_byte());
      body.insert(body.size(), 8'(plen));
      for (int k = 0; k < plen; k++) body.insert(body.size(), pick_byte());
      foreach (body[k]) crc = ccitt_next(crc, body[k]);
      if (flaw == 1) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      body.insert(body.size(), crc[15:8]);
      body.insert(body.size(), crc[7:0]);
      keep = (flaw == 2) ? $urandom_range(1, body.size() - 1) : body.size();
      feed_byte(sfd_pkg::SYNC_BYTE);
      feed_byte(sfd_pkg::SYNC_BYTE);
      for (int k = 0; k < keep; k++) feed_byte(body[k]);
   endtask

   // result side: check each transfer, stall rsp_ready in bursts
   always @(posedge clock) begin
      frame_out_type want;
      frame_out_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.frame_byte     = rsp_frame_byte;
            got.byte_offset    = rsp_byte_offset;
            got.payload_length = rsp_payload_length;
            got.frame_end      = rsp_frame_end;
            got.frame_status   = sfd_pkg::frame_status_type'(rsp_frame_status);
            if (frame_byte_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result byte %h offset %0d", $realtime,
                           rsp_frame_byte, rsp_byte_offset);
            end else begin
               want = frame_byte_queue.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch exp/act byte %h/%h offset %0d/%0d len %0d/%0d",
                               " end %0b/%0b status %0d/%0d"}, $realtime,
                              want.frame_byte, got.frame_byte, want.byte_offset,
                              got.byte_offset, want.payload_length, got.payload_length,
                              want.frame_end, got.frame_end, want.frame_status,
                              got.frame_status);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      dir_row_type   r;
      logic [7:0]    b;
      bit            has;
      frame_out_type o;
      int            long_done;
      int            plen;
      int            flaw;
      logic [7:0]    last_noise;
      long_done = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         r = directed_rows[i];
         case (r.feed)
            FEED_RAW:         b = r.value;
            FEED_CRC_HIGH:    b = crc_acc[15:8];
            FEED_CRC_LOW:     b = crc_acc[7:0];
            FEED_CRC_LOW_BAD: b = crc_acc[7:0] ^ 8'h01;
            default:          b = r.value;
         endcase
         push_byte(b);
         deframe_step(b, has, o);
         if (r.typed) begin
            if (!r.none) begin
               o.frame_byte     = b;
               o.byte_offset    = r.offset;
               o.payload_length = r.plen;
               o.frame_end      = r.fend;
               o.frame_status   = r.status;
               frame_byte_queue.insert(frame_byte_queue.size(), o);
            end
         end else if (has) begin
            frame_byte_queue.insert(frame_byte_queue.size(), o);
         end
      end

      fed_items = 0;
      while (fed_items < 850) begin
         if (fed_items >= 750) begin
            tx_idle_on  = 1'b0;
            rx_stall_on = 1'b0;
         end else begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
         end
         // line noise between frames, no back-to-back sync pair
         last_noise = 8'h00;
         repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom_range(0, 255));
            if (b == sfd_pkg::SYNC_BYTE && last_noise == sfd_pkg::SYNC_BYTE) b = 8'hA5;
            feed_byte(b);
            last_noise = b;
         end
         flaw = 0;
         if (fed_items > 250 && long_done == 0) begin
            plen = 251;
            long_done = 1;
         end else if (fed_items > 500 && long_done == 1) begin
            plen = $urandom_range(252, 255);
            long_done = 2;
         end else begin
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            case ($urandom_range(0, 9))
               0:       flaw = 1;
               1:       flaw = 2;
               default: flaw = 0;
            endcase
         end
         send_frame(plen, flaw);
      end
      req_valid <= 1'b0;

      while (frame_byte_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sfd_pkg.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/sync_frame_deframer_crc16_unit.sv
tb/testbench.sv
